// ===== rtl/blum_blum_shub_bit_generator_defines.svh =====
// Assertion macros shared by the RTL files.
`ifndef BLUM_BLUM_SHUB_BIT_GENERATOR_DEFINES_SVH
`define BLUM_BLUM_SHUB_BIT_GENERATOR_DEFINES_SVH

// Check an implication on every rising clock edge outside reset.
`define BBS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("bbs assertion failed");

// Check that a condition never holds outside reset.
`define BBS_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("bbs forbidden condition seen");

`endif

// ===== rtl/bbs_pkg.sv =====
package bbs_pkg;

   localparam int ModWidth = 32;
   localparam int CntWidth = $clog2(ModWidth);
   localparam logic [CntWidth-1:0] CntMax = CntWidth'(ModWidth - 1);

   localparam int CsrIndexWidth = 2;
   localparam logic [CsrIndexWidth-1:0] CsrModulus = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrSeed    = 2'd1;

   localparam logic [ModWidth-1:0] ModulusReset = ModWidth'(3);
   localparam logic [ModWidth-1:0] SeedReset    = ModWidth'(2);

   typedef logic [2:0] op_type;
   localparam op_type OpNone = 3'd0;
   localparam op_type OpClr  = 3'd1;
   localparam op_type OpRed  = 3'd2;
   localparam op_type OpMove = 3'd3;
   localparam op_type OpDbl  = 3'd4;
   localparam op_type OpAdd  = 3'd5;
   localparam op_type OpDone = 3'd6;

   typedef logic [2:0] cond_type;
   localparam cond_type CondNext    = 3'd0;
   localparam cond_type CondAlways  = 3'd1;
   localparam cond_type CondNoStart = 3'd2;
   localparam cond_type CondModZero = 3'd3;
   localparam cond_type CondCntNz   = 3'd4;
   localparam cond_type CondBitClr  = 3'd5;

   localparam int PcWidth = 3;
   localparam int ProgLen = 8;
   typedef logic [PcWidth-1:0] pc_type;
   localparam pc_type PcIdle = 3'd0;

   typedef struct packed {
      op_type   op;
      logic     dec;
      cond_type cond;
      pc_type   target;
   } ctl_word_type;

   typedef struct packed {
      logic cnt_nz;
      logic bit_clr;
      logic mod_zero;
   } status_type;

   localparam ctl_word_type Program [ProgLen] = '{
      '{OpNone, 1'b0, CondNoStart, 3'd0},
      '{OpClr,  1'b0, CondModZero, 3'd0},
      '{OpRed,  1'b1, CondCntNz,   3'd2},
      '{OpMove, 1'b0, CondNext,    3'd0},
      '{OpDbl,  1'b0, CondBitClr,  3'd6},
      '{OpAdd,  1'b0, CondNext,    3'd0},
      '{OpNone, 1'b1, CondCntNz,   3'd4},
      '{OpDone, 1'b0, CondAlways,  3'd0}
   };

endpackage

// ===== rtl/bbs_sequencer.sv =====
`include "blum_blum_shub_bit_generator_defines.svh"

module bbs_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  bbs_pkg::status_type   status,
   output bbs_pkg::ctl_word_type ctl,
   output logic                  idle
);

   bbs_pkg::pc_type pc_ff;
   bbs_pkg::pc_type pc_in;
   logic            take;

   assign ctl  = bbs_pkg::Program[pc_ff];
   assign idle = (pc_ff == bbs_pkg::PcIdle);

   always_comb begin
      unique case (ctl.cond)
         bbs_pkg::CondNext:    take = 1'b0;
         bbs_pkg::CondAlways:  take = 1'b1;
         bbs_pkg::CondNoStart: take = !start;
         bbs_pkg::CondModZero: take = status.mod_zero;
         bbs_pkg::CondCntNz:   take = status.cnt_nz;
         bbs_pkg::CondBitClr:  take = status.bit_clr;
         default:              take = 1'b0;
      endcase
      pc_in = take ? ctl.target : pc_ff + bbs_pkg::pc_type'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= bbs_pkg::PcIdle;
      end else begin
         pc_ff <= pc_in;
      end
   end

   `BBS_NEVER(a_start_only_idle, clock, reset, start && (pc_ff != bbs_pkg::PcIdle))

endmodule

// ===== rtl/bbs_datapath.sv =====
`include "blum_blum_shub_bit_generator_defines.svh"

module bbs_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  bbs_pkg::ctl_word_type        ctl,
   input  logic                         start,
   input  logic                         restart,
   input  logic [bbs_pkg::ModWidth-1:0] modulus,
   input  logic [bbs_pkg::ModWidth-1:0] seed,
   output logic [bbs_pkg::ModWidth-1:0] x_now,
   output bbs_pkg::status_type          status
);

   logic [bbs_pkg::ModWidth-1:0] x_ff, x_in;
   logic [bbs_pkg::ModWidth-1:0] r_ff, r_in;
   logic [bbs_pkg::ModWidth-1:0] a_ff, a_in;
   logic [bbs_pkg::CntWidth-1:0] cnt_ff, cnt_in;
   logic                         seeded_ff, seeded_in;

   logic [bbs_pkg::ModWidth-1:0] op_b;
   logic                         carry_in;
   logic [bbs_pkg::ModWidth:0]   sum;
   logic [bbs_pkg::ModWidth+1:0] diff;
   logic [bbs_pkg::ModWidth-1:0] sum_mod;

   assign x_now = (restart || !seeded_ff) ? seed : x_ff;

   assign status.cnt_nz   = (cnt_ff != '0);
   assign status.bit_clr  = !a_ff[cnt_ff];
   assign status.mod_zero = (modulus == '0);

   always_comb begin
      op_b     = (ctl.op == bbs_pkg::OpAdd) ? a_ff : r_ff;
      carry_in = (ctl.op == bbs_pkg::OpRed) ? x_ff[cnt_ff] : 1'b0;
      sum      = {1'b0, r_ff} + {1'b0, op_b} + {{bbs_pkg::ModWidth{1'b0}}, carry_in};
      diff     = {1'b0, sum} - {2'b00, modulus};
      sum_mod  = diff[bbs_pkg::ModWidth+1] ? sum[bbs_pkg::ModWidth-1:0]
                                          : diff[bbs_pkg::ModWidth-1:0];
   end

   always_comb begin
      x_in      = x_ff;
      r_in      = r_ff;
      a_in      = a_ff;
      cnt_in    = cnt_ff;
      seeded_in = seeded_ff;
      unique case (ctl.op)
         bbs_pkg::OpClr: begin
            r_in   = '0;
            cnt_in = bbs_pkg::CntMax;
         end
         bbs_pkg::OpRed, bbs_pkg::OpDbl, bbs_pkg::OpAdd: begin
            r_in = sum_mod;
         end
         bbs_pkg::OpMove: begin
            a_in   = r_ff;
            r_in   = '0;
            cnt_in = bbs_pkg::CntMax;
         end
         bbs_pkg::OpDone: begin
            x_in = r_ff;
         end
         default: begin
         end
      endcase
      if (ctl.dec) begin
         cnt_in = cnt_ff - {{(bbs_pkg::CntWidth-1){1'b0}}, 1'b1};
      end
      if (start) begin
         x_in      = x_now;
         seeded_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff      <= '0;
         seeded_ff <= 1'b0;
      end else begin
         x_ff      <= x_in;
         seeded_ff <= seeded_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff   <= r_in;
      a_ff   <= a_in;
      cnt_ff <= cnt_in;
   end

   `BBS_ASSERT(a_result_reduced, clock, reset, (ctl.op == bbs_pkg::OpDone) |-> (r_ff < modulus))

endmodule

// ===== rtl/blum_blum_shub_bit_generator.sv =====
// Blum Blum Shub bit generator.
// Program modulus (csr index 0) and seed (csr index 1) through the write
// port while the block is idle; writes to other indexes are dropped.
// Each request beat on req_ carries a restart flag and returns one response
// beat on rsp_: the least significant bit of the running value and the value itself.
// The first request after reset, or one with restart set, reloads the
// running value from seed before it is emitted.
// The response is registered in the cycle after the request is accepted.
// The running value is then squared modulo the modulus by a microcoded
// shift-add loop over the 32 bits: 32 reduction steps, then per bit one
// doubling plus one conditional add and a count step, all through the single
// modular adder; the next request is accepted only once the loop is done.
// A zero modulus skips the squaring and the block returns straight to idle.
// A stalled response holds its beat; no new request is taken until the
// response register is free or being drained.
// Reset (synchronous, active high) restores modulus 3, seed 2 and forces a
// reload on the next request.
`include "blum_blum_shub_bit_generator_defines.svh"

module blum_blum_shub_bit_generator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_restart,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_random_bit,
   output logic [31:0]                       rsp_running_value,
   input  logic                              csr_wr_en,
   input  logic [bbs_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [31:0]                       csr_wdata
);

   logic [bbs_pkg::ModWidth-1:0] modulus_ff, modulus_in;
   logic [bbs_pkg::ModWidth-1:0] seed_ff, seed_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [31:0]                  rsp_value_ff, rsp_value_in;

   bbs_pkg::ctl_word_type        ctl;
   bbs_pkg::status_type          status;
   logic                         idle;
   logic                         start;
   logic [bbs_pkg::ModWidth-1:0] x_now;

   assign req_ready         = idle && (!rsp_valid_ff || rsp_ready);
   assign start             = req_valid && req_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_running_value = rsp_value_ff;
   assign rsp_random_bit    = rsp_value_ff[0];

   bbs_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .ctl    (ctl),
      .idle   (idle)
   );

   bbs_datapath u_dp (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .start   (start),
      .restart (req_restart),
      .modulus (modulus_ff),
      .seed    (seed_ff),
      .x_now   (x_now),
      .status  (status)
   );

   always_comb begin
      modulus_in = modulus_ff;
      seed_in    = seed_ff;
      if (csr_wr_en) begin
         priority if (csr_index == bbs_pkg::CsrModulus) begin
            modulus_in = csr_wdata[bbs_pkg::ModWidth-1:0];
         end else if (csr_index == bbs_pkg::CsrSeed) begin
            seed_in = csr_wdata[bbs_pkg::ModWidth-1:0];
         end else begin
         end
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (start) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = 32'(x_now);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= bbs_pkg::ModulusReset;
         seed_ff      <= bbs_pkg::SeedReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         modulus_ff   <= modulus_in;
         seed_ff      <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
   end

   `BBS_ASSERT(a_accept_gives_beat, clock, reset, start |=> rsp_valid_ff)
   `BBS_ASSERT(a_beat_holds_seed, clock, reset, start && req_restart |=> rsp_value_ff == $past(seed_ff))

endmodule
